[rtl/bpt_pkg.sv]
// types, constants and small helpers shared by the patch tessellator
// no dependencies; imported by every other file of the block

package bpt_pkg;

    localparam int VAL_W    = 32;
    localparam int WT_W     = 5;
    localparam int NUM_ATTR = 9;
    localparam int ACC_W    = 40;
    localparam int DIV_STEPS = ACC_W / 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic REG_TESS = 1'b0;
    localparam logic [2:0] TESS_RESET = 3'd5;

    localparam logic [3:0] ATTR_X       = 4'd0;
    localparam logic [3:0] ATTR_Y       = 4'd1;
    localparam logic [3:0] ATTR_Z       = 4'd2;
    localparam logic [3:0] ATTR_RED     = 4'd3;
    localparam logic [3:0] ATTR_GREEN   = 4'd4;
    localparam logic [3:0] ATTR_BLUE    = 4'd5;
    localparam logic [3:0] ATTR_ALPHA   = 4'd6;
    localparam logic [3:0] ATTR_TEX_S   = 4'd7;
    localparam logic [3:0] ATTR_TEX_T   = 4'd8;
    localparam logic [3:0] ATTR_LAST    = ATTR_TEX_T;

    typedef struct packed {
        logic               cmd;
        logic [3:0]         point_index;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic [7:0]         in_red;
        logic [7:0]         in_green;
        logic [7:0]         in_blue;
        logic [7:0]         in_alpha;
        logic signed [31:0] in_tex_s;
        logic signed [31:0] in_tex_t;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_alpha;
        logic signed [31:0] out_tex_s;
        logic signed [31:0] out_tex_t;
        logic               strip_end;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic signed [31:0] tex_s;
        logic signed [31:0] tex_t;
    } vert_t;

    // one blend job: three operands, three weights, divisor n*n
    typedef struct packed {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic signed [VAL_W-1:0] c;
        logic [WT_W-1:0]         w0;
        logic [WT_W-1:0]         w1;
        logic [WT_W-1:0]         w2;
        logic [WT_W-1:0]         d;
    } blend_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] value;
    } blend_rsp_t;

    typedef struct packed {
        logic [WT_W-1:0] w0;
        logic [WT_W-1:0] w1;
        logic [WT_W-1:0] w2;
        logic [WT_W-1:0] d;
    } weights_t;

    function automatic weights_t calc_weights(logic [2:0] k, logic [2:0] n);
        logic [2:0]      nk;
        logic [WT_W-1:0] nk_w;
        logic [WT_W-1:0] k_w;
        logic [WT_W-1:0] n_w;
        weights_t        w;
        nk   = n - k;
        nk_w = {2'b00, nk};
        k_w  = {2'b00, k};
        n_w  = {2'b00, n};
        w.w0 = nk_w * nk_w;
        w.w1 = {nk_w[WT_W-2:0], 1'b0} * k_w;
        w.w2 = k_w * k_w;
        w.d  = n_w * n_w;
        return w;
    endfunction

    function automatic logic signed [VAL_W-1:0] attr_get(vert_t v, logic [3:0] idx);
        logic signed [VAL_W-1:0] r;
        unique case (idx)
            ATTR_X:     r = v.x;
            ATTR_Y:     r = v.y;
            ATTR_Z:     r = v.z;
            ATTR_RED:   r = {24'd0, v.red};
            ATTR_GREEN: r = {24'd0, v.green};
            ATTR_BLUE:  r = {24'd0, v.blue};
            ATTR_ALPHA: r = {24'd0, v.alpha};
            ATTR_TEX_S: r = v.tex_s;
            ATTR_TEX_T: r = v.tex_t;
            default:    r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sat_color(logic signed [VAL_W-1:0] val);
        logic [7:0] r;
        if (val < 0)
            r = 8'd0;
        else if (val > 32'sd255)
            r = 8'd255;
        else
            r = val[7:0];
        return r;
    endfunction

    function automatic vert_t attr_set(vert_t v, logic [3:0] idx,
                                       logic signed [VAL_W-1:0] val);
        vert_t r;
        r = v;
        unique case (idx)
            ATTR_X:     r.x = val;
            ATTR_Y:     r.y = val;
            ATTR_Z:     r.z = val;
            ATTR_RED:   r.red = sat_color(val);
            ATTR_GREEN: r.green = sat_color(val);
            ATTR_BLUE:  r.blue = sat_color(val);
            ATTR_ALPHA: r.alpha = sat_color(val);
            ATTR_TEX_S: r.tex_s = val;
            ATTR_TEX_T: r.tex_t = val;
            default:    r = v;
        endcase
        return r;
    endfunction

    function automatic out_item_t to_out(vert_t v, logic se, logic lst);
        out_item_t o;
        o.out_x     = v.x;
        o.out_y     = v.y;
        o.out_z     = v.z;
        o.out_red   = v.red;
        o.out_green = v.green;
        o.out_blue  = v.blue;
        o.out_alpha = v.alpha;
        o.out_tex_s = v.tex_s;
        o.out_tex_t = v.tex_t;
        o.strip_end = se;
        o.last      = lst;
        return o;
    endfunction

    function automatic vert_t from_in(in_item_t i);
        vert_t v;
        v.x     = i.in_x;
        v.y     = i.in_y;
        v.z     = i.in_z;
        v.red   = i.in_red;
        v.green = i.in_green;
        v.blue  = i.in_blue;
        v.alpha = i.in_alpha;
        v.tex_s = i.in_tex_s;
        v.tex_t = i.in_tex_t;
        return v;
    endfunction

    // slot to (row, column) of the 3x3 grid
    function automatic logic [1:0] slot_row(logic [3:0] s);
        logic [1:0] r;
        case (s)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] slot_col(logic [3:0] s);
        logic [1:0] c;
        case (s)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

[rtl/bpt_blend_unit.sv]
// shared weighted-sum unit: three multiply-accumulate steps, then floor
// division by n*n one radix-16 digit per cycle; uses bpt_pkg

module bpt_blend_unit import bpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  blend_req_t req,
    output blend_rsp_t rsp
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MAC  = 3'b010,
        B_DIV  = 3'b100
    } bstate_t;

    bstate_t                 state_reg, state_next;
    logic [3:0]              cnt_reg, cnt_next;
    blend_req_t              job_reg, job_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [4:0]              rem_reg, rem_next;
    logic [VAL_W-1:0]        quot_reg, quot_next;
    logic                    done_reg, done_next;
    logic signed [VAL_W-1:0] value_reg, value_next;

    logic signed [VAL_W-1:0] opnd;
    logic [WT_W-1:0]         wt;
    logic signed [VAL_W+WT_W:0] prod;
    logic [8:0]              part;
    logic [3:0]              digit;
    logic [8:0]              digit_mul;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin opnd = job_reg.a; wt = job_reg.w0; end
            2'd1:    begin opnd = job_reg.b; wt = job_reg.w1; end
            default: begin opnd = job_reg.c; wt = job_reg.w2; end
        endcase
        prod = opnd * $signed({1'b0, wt});
    end

    // quotient digit: count of multiples of d that fit in the partial remainder
    always_comb
    begin
        part  = {rem_reg, acc_reg[ACC_W-1 -: 4]};
        digit = '0;
        for (int j = 1; j < 16; j++)
        begin
            if (part >= 9'({4'd0, job_reg.d} * 9'(j)))
                digit = digit + 4'd1;
        end
        digit_mul = 9'({5'd0, digit} * {4'd0, job_reg.d});
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        job_next   = job_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        value_next = value_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    job_next   = req;
                    // offset by d*2^31 keeps the sum non-negative
                    acc_next   = ACC_W'(req.d) << 31;
                    cnt_next   = '0;
                    state_next = B_MAC;
                end
            end
            B_MAC:
            begin
                acc_next = acc_reg + ACC_W'(prod);
                if (cnt_reg == 4'd2)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    quot_next  = '0;
                    state_next = B_DIV;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            B_DIV:
            begin
                acc_next  = acc_reg << 4;
                rem_next  = 5'(part - digit_mul);
                quot_next = {quot_reg[VAL_W-5:0], digit};
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    // remove the 2^31 offset
                    value_next = $signed({~quot_reg[VAL_W-5], quot_reg[VAL_W-6:0], digit});
                    state_next = B_IDLE;
                end
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        value_reg <= value_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;

endmodule

[rtl/biquadratic_patch_tessellator_unit.sv]
// top level of the biquadratic patch tessellator: control store, sequencer,
// output register and register port; uses bpt_pkg and bpt_blend_unit
//
// usage
//   item channel (item_valid/item_ready/item): cmd load writes one of nine
//   control vertices (point_index 0 to 8); cmd draw tessellates the patch at the
//   current tess_level and streams 2*n*(n+1) vertices on the vert channel
//   (vert_valid/vert_ready/vert), one strip per u step, previous-row vertex
//   then current-row vertex, strip_end on the last of each strip and last
//   on the final vertex of the patch
//   item_ready is high only while the sequencer is idle; a draw holds it low
//   until the final vertex sits in the output register
//   jobs: every vertex attribute is one job of the shared blend unit, made of
//   three multiply-accumulate steps and ten radix-16 divide steps; a draw runs
//   9*(3*(n+1) + (n+1)^2) jobs one after another on that single unit, which
//   sets the pace of the draw
//   stalls: the output register holds a vertex until its transfer; the
//   sequencer simply waits, nothing is dropped
//   reset: control store cleared to zero, tess_level back to 5, no vertex
//   pending; configuration is written through the apb-style port

module biquadratic_patch_tessellator_unit import bpt_pkg::*;
#(
    parameter int MAX_TESS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        item_valid,
    output logic        item_ready,
    input  in_item_t    item,
    // vertex channel
    output logic        vert_valid,
    input  logic        vert_ready,
    output out_item_t   vert,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROWS = MAX_TESS + 1;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_COL  = 5'b00010,
        S_ROW  = 5'b00100,
        S_PREV = 5'b01000,
        S_CUR  = 5'b10000
    } state_t;

    // register port
    logic [2:0] tess_reg;
    logic       reg_wr;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_TESS);
    assign prdata = (paddr[2] == REG_TESS) ? {29'd0, tess_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tess_reg <= TESS_RESET;
        else if (reg_wr)
            tess_reg <= pwdata[2:0];
    end

    // sequencer state
    state_t     state_reg, state_next;
    logic [2:0] n_reg, n_next;
    logic [RW-1:0] u_reg, u_next;
    logic [RW-1:0] v_reg, v_next;
    logic [1:0] r_reg, r_next;
    logic [3:0] attr_reg, attr_next;
    logic       issued_reg, issued_next;
    vert_t      nv_reg, nv_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;

    // stores: control grid as [row][column], column results, previous row
    vert_t ctrl_reg [3][3];
    vert_t col_reg [3];
    vert_t row_reg [ROWS];

    logic          col_we;
    vert_t         col_wd;
    logic          row_we;
    vert_t         row_wd;
    logic          ctrl_we;
    logic [1:0]    ctrl_wr_row;
    logic [1:0]    ctrl_wr_col;

    // shared unit
    logic       blend_start;
    blend_req_t blend_req;
    blend_rsp_t blend_rsp;
    weights_t   wts;
    logic [2:0] k_sel;
    logic [2:0] n_clamp;
    logic       out_free;
    logic       v_at_end;
    logic       u_at_end;
    vert_t      nv_new;

    bpt_blend_unit u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (blend_start),
        .req   (blend_req),
        .rsp   (blend_rsp)
    );

    // level zero runs as one, anything above the maximum as the maximum
    always_comb
    begin
        if (tess_reg == 3'd0)
            n_clamp = 3'd1;
        else if (tess_reg > 3'(MAX_TESS))
            n_clamp = 3'(MAX_TESS);
        else
            n_clamp = tess_reg;
    end

    assign k_sel = (state_reg == S_COL) ? 3'(u_reg) : 3'(v_reg);
    assign wts   = calc_weights(k_sel, n_reg);

    // operands: u direction reads one control row, v direction the columns
    always_comb
    begin
        blend_req.w0 = wts.w0;
        blend_req.w1 = wts.w1;
        blend_req.w2 = wts.w2;
        blend_req.d  = wts.d;
        if (state_reg == S_COL)
        begin
            blend_req.a = attr_get(ctrl_reg[r_reg][0], attr_reg);
            blend_req.b = attr_get(ctrl_reg[r_reg][1], attr_reg);
            blend_req.c = attr_get(ctrl_reg[r_reg][2], attr_reg);
        end
        else
        begin
            blend_req.a = attr_get(col_reg[0], attr_reg);
            blend_req.b = attr_get(col_reg[1], attr_reg);
            blend_req.c = attr_get(col_reg[2], attr_reg);
        end
    end

    assign blend_start = ((state_reg == S_COL) || (state_reg == S_ROW)) && !issued_reg;
    assign out_free    = !out_valid_reg || vert_ready;
    assign v_at_end    = (3'(v_reg) == n_reg);
    assign u_at_end    = (3'(u_reg) == n_reg);
    assign nv_new      = attr_set(nv_reg, attr_reg, blend_rsp.value);

    // loads land in the control store straight from the item transfer
    assign item_ready  = (state_reg == S_IDLE);
    assign ctrl_we     = item_valid && item_ready && (item.cmd == CMD_LOAD)
                         && (item.point_index <= 4'd8);
    assign ctrl_wr_row = slot_row(item.point_index);
    assign ctrl_wr_col = slot_col(item.point_index);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        r_next         = r_reg;
        attr_next      = attr_reg;
        nv_next        = nv_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !vert_ready;
        col_we         = 1'b0;
        col_wd         = attr_set(col_reg[r_reg], attr_reg, blend_rsp.value);
        row_we         = 1'b0;
        row_wd         = nv_new;

        issued_next = issued_reg;
        if (blend_start)
            issued_next = 1'b1;
        if (blend_rsp.done)
            issued_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && (item.cmd == CMD_DRAW))
                begin
                    n_next     = n_clamp;
                    u_next     = '0;
                    r_next     = '0;
                    attr_next  = ATTR_X;
                    state_next = S_COL;
                end
            end
            S_COL:
            begin
                if (blend_rsp.done)
                begin
                    col_we = 1'b1;
                    if (attr_reg == ATTR_LAST)
                    begin
                        attr_next = ATTR_X;
                        if (r_reg == 2'd2)
                        begin
                            r_next     = '0;
                            v_next     = '0;
                            state_next = S_ROW;
                        end
                        else
                            r_next = r_reg + 2'd1;
                    end
                    else
                        attr_next = attr_reg + 4'd1;
                end
            end
            S_ROW:
            begin
                if (blend_rsp.done)
                begin
                    nv_next = nv_new;
                    if (attr_reg == ATTR_LAST)
                    begin
                        attr_next = ATTR_X;
                        if (u_reg == '0)
                        begin
                            // first row of a draw only primes the row store
                            row_we = 1'b1;
                            if (v_at_end)
                            begin
                                u_next     = RW'(1);
                                state_next = S_COL;
                            end
                            else
                                v_next = v_reg + RW'(1);
                        end
                        else
                            state_next = S_PREV;
                    end
                    else
                        attr_next = attr_reg + 4'd1;
                end
            end
            S_PREV:
            begin
                if (out_free)
                begin
                    out_next       = to_out(row_reg[v_reg], 1'b0, 1'b0);
                    out_valid_next = 1'b1;
                    row_we         = 1'b1;
                    row_wd         = nv_reg;
                    state_next     = S_CUR;
                end
            end
            S_CUR:
            begin
                if (out_free)
                begin
                    out_next       = to_out(nv_reg, v_at_end, v_at_end && u_at_end);
                    out_valid_next = 1'b1;
                    if (v_at_end)
                    begin
                        if (u_at_end)
                            state_next = S_IDLE;
                        else
                        begin
                            u_next     = u_reg + RW'(1);
                            state_next = S_COL;
                        end
                    end
                    else
                    begin
                        v_next     = v_reg + RW'(1);
                        state_next = S_ROW;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= 3'd1;
            u_reg         <= '0;
            v_reg         <= '0;
            r_reg         <= '0;
            attr_reg      <= ATTR_X;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            r_reg         <= r_next;
            attr_reg      <= attr_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // control store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    ctrl_reg[i][j] <= '0;
            end
        end
        else if (ctrl_we)
            ctrl_reg[ctrl_wr_row][ctrl_wr_col] <= from_in(item);
    end

    // working stores, always written before they are read
    always_ff @(posedge clk)
    begin
        nv_reg  <= nv_next;
        out_reg <= out_next;
        if (col_we)
            col_reg[r_reg] <= col_wd;
        if (row_we)
            row_reg[v_reg] <= row_wd;
    end

    assign vert_valid = out_valid_reg;
    assign vert       = out_reg;

endmodule

[rtl/bpt_checker.sv]
// port-level checks for the patch tessellator, bound to the top level
// uses bpt_pkg

module bpt_checker import bpt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input in_item_t  item,
    input logic      vert_valid,
    input logic      vert_ready,
    input out_item_t vert
);

    // a stalled vertex stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && !vert_ready |=> vert_valid && $stable(vert))
        else $error("stalled vertex changed");

    // the final vertex of the patch also closes a strip
    assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && vert.last |-> vert.strip_end)
        else $error("last without strip_end");

    // an accepted draw closes the item channel
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.cmd == CMD_DRAW) |=> !item_ready)
        else $error("item accepted during draw");

    // a load produces no vertex of its own
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.cmd == CMD_LOAD) && !vert_valid
        |=> !vert_valid)
        else $error("vertex after load");

endmodule

bind biquadratic_patch_tessellator_unit bpt_checker u_bpt_checker (.*);
